// ----- rtl/core/msx_pkg.sv -----
package msx_pkg;

  localparam logic [31:0] DATA_BASE = 32'h1000_0000;
  localparam logic [31:0] GP_INIT   = 32'h1000_8000;
  localparam logic [31:0] PC_INIT   = 32'h0040_0000;

  // writer window depth; distances travel in a 4-bit field
  localparam int WINDOW_DEPTH = 8;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_TRAP    = 6'h1a;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1a;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_SLT  = 6'h2a;

  // trap codes
  localparam logic [3:0] TR_NEWLINE = 4'h0;
  localparam logic [3:0] TR_PRINT   = 4'h1;
  localparam logic [3:0] TR_READ    = 4'h5;
  localparam logic [3:0] TR_HALT    = 4'ha;

  localparam logic [1:0] PK_NONE    = 2'd0;
  localparam logic [1:0] PK_NEWLINE = 2'd1;
  localparam logic [1:0] PK_INT     = 2'd2;
  localparam logic [1:0] PK_PROMPT  = 2'd3;

  localparam logic [4:0] REG_RA = 5'd31;

  typedef enum logic [2:0] {
    ST_OK, ST_HALT, ST_BAD_INSTR, ST_BAD_TRAP, ST_DIV_ZERO, ST_UNALIGNED, ST_RANGE
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_MEM_CHK, S_MEM_RD, S_MULDIV, S_FINISH
  } fsm_t;

  typedef enum logic {MD_MUL, MD_DIV} md_op_t;

  typedef struct packed {
    logic [31:0] npc;
    status_t     st;
    logic [1:0]  pk;
    logic [31:0] pv;
    logic [3:0]  dr;
    logic [3:0]  dt;
    logic [5:0]  cyc_inc;
    logic        br_inc;
    logic        mem_inc;
    logic [1:0]  zero_inc;
    logic [1:0]  acc_inc;
    logic        ins_inc;
    logic        push_en;
    logic [4:0]  push_reg;
    logic        gw_en;
    logic [4:0]  gw_addr;
    logic [31:0] gw_data;
    logic        hl_en;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] ea;
    logic [31:0] sdata;
    logic        is_lw;
  } pend_t;

endpackage

// ----- rtl/core/msx_ram.sv -----
module msx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/msx_muldiv.sv -----
module msx_muldiv (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  msx_pkg::md_op_t op,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  output logic            done,
  output logic [31:0]     hi,
  output logic [31:0]     lo
);
  import msx_pkg::*;

  logic        busy_r, busy_nxt;
  logic        fin_r, fin_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] p_r, p_nxt;
  logic [31:0] mc_r, mc_nxt;
  logic        negq_r, negq_nxt;
  logic        negr_r, negr_nxt;
  md_op_t      op_r, op_nxt;

  logic [31:0] ma, mb;
  logic [32:0] msum, rem_sh, diff;
  logic [63:0] prod;

  always_comb begin
    ma = a[31] ? 32'(0 - a) : a;
    mb = b[31] ? 32'(0 - b) : b;
    msum   = {1'b0, p_r[63:32]} + (p_r[0] ? {1'b0, mc_r} : 33'd0);
    rem_sh = {p_r[63:32], p_r[31]};
    diff   = rem_sh - {1'b0, mc_r};

    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    p_nxt    = p_r;
    mc_nxt   = mc_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    op_nxt   = op_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      p_nxt    = {32'd0, ma};
      mc_nxt   = mb;
      negq_nxt = a[31] ^ b[31];
      negr_nxt = a[31];
      op_nxt   = op;
    end else if (busy_r) begin
      // one bit of multiplier or quotient per cycle
      if (op_r == MD_MUL) begin
        p_nxt = {msum, p_r[31:1]};
      end else if (!diff[32]) begin
        p_nxt = {diff[31:0], p_r[30:0], 1'b1};
      end else begin
        p_nxt = {rem_sh[31:0], p_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
    cnt_r  <= cnt_nxt;
    p_r    <= p_nxt;
    mc_r   <= mc_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
    op_r   <= op_nxt;
  end

  always_comb begin
    prod = negq_r ? 64'(0 - p_r) : p_r;
    if (op_r == MD_MUL) begin
      hi = prod[63:32];
      lo = prod[31:0];
    end else begin
      lo = negq_r ? 32'(0 - p_r[31:0]) : p_r[31:0];
      hi = negr_r ? 32'(0 - p_r[63:32]) : p_r[63:32];
    end
  end

  assign done = fin_r;

endmodule

// ----- rtl/core/mips_subset_execute_with_stats.sv -----
// Steps: register ops pass EXEC then FINISH; sw adds MEM_CHK, lw adds MEM_CHK and MEM_RD;
// mult and div wait in MULDIV (the shared shift-add / restore-subtract unit takes one bit per cycle).
// Throughput: one item at a time; a new item is taken once the previous one is finished.
// Reset (synchronous, rst_n low): control, counters and the writer window clear, pc loads
// the default entry address, then a clearing pass over all DATA_WORDS words zeroes data memory
// and presets the register file; no item is accepted during that pass, configuration is.
module mips_subset_execute_with_stats #(
  parameter int DATA_WORDS   = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,    // start_pc
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,     // instr_word[31:0], read_value[63:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  // next_pc[31:0], status[34:32], print_value[66:35], rs_distance[70:67],
  // rt_distance[74:71], cycle_total[106:75], branch_total[138:107],
  // memory_total[170:139], zero_total[202:171], access_total[234:203],
  // instr_total[266:235], zero fill[271:267]
  output logic [271:0] out_tdata,
  output logic [1:0]   out_tuser     // print_kind[1:0]
);
  import msx_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);
  localparam int DW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [31:0] SP_INIT = 32'(DATA_BASE + 32'(DATA_WORDS * 4));
  localparam logic [32:0] DM_BYTES = 33'(DATA_WORDS * 4);

  fsm_t  state_r, state_nxt;
  pend_t pend_r, pend_nxt;

  logic [AW-1:0] clr_r;
  logic [31:0]   pc_r, hi_r, lo_r;
  logic [31:0]   cyc_r, br_r, mem_r, zero_r, acc_r, ins_r;
  logic          halted_r;
  logic [4:0]    win_r [WINDOW_DEPTH];
  logic [31:0]   instr_r, rdv_r;
  logic          out_valid_r;
  logic [271:0]  out_data_r;
  logic [1:0]    out_user_r;

  // decoded fields of the held instruction
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] uimm, simm, pc4, rsv, rtv;
  logic [31:0] gpr_a, gpr_b;

  // register file: two copies, one per read port, written together
  logic        gw_en;
  logic [4:0]  gw_addr;
  logic [31:0] gw_data;

  // data memory
  logic          dm_we;
  logic [AW-1:0] dm_waddr, dm_raddr;
  logic [31:0]   dm_wdata, dm_rdata;
  logic [32:0]   dm_off;

  logic          md_start, md_done;
  md_op_t        md_op;
  logic [31:0]   md_hi, md_lo;

  logic [DW-1:0] dist_rs, dist_rt;
  logic          fin_go;
  logic [31:0]   cyc_new, br_new, mem_new, zero_new, acc_new, ins_new;

  assign op   = instr_r[31:26];
  assign rs   = instr_r[25:21];
  assign rt   = instr_r[20:16];
  assign rd   = instr_r[15:11];
  assign sh   = instr_r[10:6];
  assign fn   = instr_r[5:0];
  assign uimm = {16'd0, instr_r[15:0]};
  assign simm = {{16{instr_r[15]}}, instr_r[15:0]};
  assign pc4  = pc_r + 32'd4;
  assign rsv  = (rs == 5'd0) ? 32'd0 : gpr_a;
  assign rtv  = (rt == 5'd0) ? 32'd0 : gpr_b;

  msx_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_a (
    .clk(clk), .we(gw_en), .waddr(gw_addr), .wdata(gw_data),
    .raddr(in_tdata[25:21]), .rdata(gpr_a)
  );

  msx_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_b (
    .clk(clk), .we(gw_en), .waddr(gw_addr), .wdata(gw_data),
    .raddr(in_tdata[20:16]), .rdata(gpr_b)
  );

  msx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_raddr), .rdata(dm_rdata)
  );

  msx_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .start(md_start), .op(md_op),
    .a(rsv), .b(rtv), .done(md_done), .hi(md_hi), .lo(md_lo)
  );

  // Distance search over the writer window: newest entry wins.
  always_comb begin
    dist_rs = '0;
    dist_rt = '0;
    for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
      if (win_r[i] == rs) dist_rs = DW'(i + 1);
      if (win_r[i] == rt) dist_rt = DW'(i + 1);
    end
    if (rs == 5'd0) dist_rs = '0;
    if (rt == 5'd0) dist_rt = '0;
  end

  // Word offset of the held effective address.
  assign dm_off   = {1'b0, pend_r.ea} - {1'b0, DATA_BASE};
  assign dm_raddr = dm_off[AW+1:2];

  // Memory write port: clearing pass, else store.
  always_comb begin
    if (state_r == S_CLEAR) begin
      dm_we    = 1'b1;
      dm_waddr = clr_r;
      dm_wdata = '0;
    end else begin
      dm_we    = (state_r == S_MEM_CHK) && !pend_r.is_lw && (pend_r.ea[1:0] == 2'b00) &&
                 (dm_off < DM_BYTES);
      dm_waddr = dm_raddr;
      dm_wdata = pend_r.sdata;
    end
  end

  // Register file write port: preset during the clearing pass, else commit.
  always_comb begin
    if (state_r == S_CLEAR) begin
      gw_en   = (32'(clr_r) < 32'd32);
      gw_addr = clr_r[4:0];
      if (clr_r[4:0] == 5'd28) gw_data = GP_INIT;
      else if (clr_r[4:0] == 5'd29) gw_data = SP_INIT;
      else gw_data = '0;
    end else begin
      gw_en   = fin_go && pend_r.gw_en && (pend_r.gw_addr != 5'd0);
      gw_addr = pend_r.gw_addr;
      gw_data = pend_r.gw_data;
    end
  end

  assign fin_go   = (state_r == S_FINISH) && (!out_valid_r || out_tready);
  assign cyc_new  = cyc_r + 32'(pend_r.cyc_inc);
  assign br_new   = br_r + 32'(pend_r.br_inc);
  assign mem_new  = mem_r + 32'(pend_r.mem_inc);
  assign zero_new = zero_r + 32'(pend_r.zero_inc);
  assign acc_new  = acc_r + 32'(pend_r.acc_inc);
  assign ins_new  = ins_r + 32'(pend_r.ins_inc);

  assign in_tready = (state_r == S_IDLE);

  // Sequencer: decode, then memory or multiply/divide, then commit.
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    md_start  = 1'b0;
    md_op     = MD_MUL;

    unique case (state_r)
      S_CLEAR: begin
        if (32'(clr_r) == 32'(DATA_WORDS - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end

      S_EXEC: begin
        pend_nxt = '0;
        pend_nxt.npc = pc4;
        pend_nxt.st  = ST_OK;
        pend_nxt.ins_inc = 1'b1;
        pend_nxt.ea    = rsv + simm;
        pend_nxt.sdata = rtv;
        pend_nxt.is_lw = (op == OP_LW);
        state_nxt = S_FINISH;
        if (halted_r) begin
          // already stopped: report the held pc, change nothing
          pend_nxt.npc = pc_r;
          pend_nxt.st  = ST_HALT;
          pend_nxt.ins_inc = 1'b0;
        end else begin
          unique case (op)
            OP_SPECIAL: begin
              unique case (fn)
                FN_SLL, FN_SRA: begin
                  pend_nxt.gw_en   = 1'b1;
                  pend_nxt.gw_addr = rd;
                  pend_nxt.gw_data = (fn == FN_SLL) ? (rtv << sh) : 32'($signed(rtv) >>> sh);
                  pend_nxt.dt       = 4'(dist_rt);
                  pend_nxt.push_en  = 1'b1;
                  pend_nxt.push_reg = rd;
                  pend_nxt.cyc_inc  = 6'd2;
                  pend_nxt.acc_inc  = 2'd1;
                  pend_nxt.zero_inc = {1'b0, rt == 5'd0};
                end
                FN_JR: begin
                  pend_nxt.npc      = rsv;
                  pend_nxt.dr       = 4'(dist_rs);
                  pend_nxt.push_en  = 1'b1;
                  pend_nxt.cyc_inc  = 6'd2;
                  pend_nxt.acc_inc  = 2'd1;
                  pend_nxt.zero_inc = {1'b0, rs == 5'd0};
                end
                FN_MFHI, FN_MFLO: begin
                  pend_nxt.gw_en    = 1'b1;
                  pend_nxt.gw_addr  = rd;
                  pend_nxt.gw_data  = (fn == FN_MFHI) ? hi_r : lo_r;
                  pend_nxt.push_en  = 1'b1;
                  pend_nxt.push_reg = rd;
                  pend_nxt.cyc_inc  = 6'd2;
                  pend_nxt.acc_inc  = 2'd1;
                end
                FN_MULT: begin
                  md_start = 1'b1;
                  md_op    = MD_MUL;
                  pend_nxt.dr       = 4'(dist_rs);
                  pend_nxt.dt       = 4'(dist_rt);
                  pend_nxt.zero_inc = 2'(rs == 5'd0) + 2'(rt == 5'd0);
                  pend_nxt.cyc_inc  = 6'd32;
                  pend_nxt.acc_inc  = 2'd2;
                  pend_nxt.push_en  = 1'b1;
                  state_nxt = S_MULDIV;
                end
                FN_DIV: begin
                  if (rtv == 32'd0) begin
                    pend_nxt.st = ST_DIV_ZERO;
                  end else begin
                    md_start = 1'b1;
                    md_op    = MD_DIV;
                    pend_nxt.dr       = 4'(dist_rs);
                    pend_nxt.dt       = 4'(dist_rt);
                    pend_nxt.zero_inc = {1'b0, rs == 5'd0};
                    pend_nxt.cyc_inc  = 6'd32;
                    pend_nxt.acc_inc  = 2'd2;
                    pend_nxt.push_en  = 1'b1;
                    state_nxt = S_MULDIV;
                  end
                end
                FN_ADDU, FN_SUBU, FN_SLT: begin
                  pend_nxt.gw_en   = 1'b1;
                  pend_nxt.gw_addr = rd;
                  if (fn == FN_ADDU) pend_nxt.gw_data = rsv + rtv;
                  else if (fn == FN_SUBU) pend_nxt.gw_data = rsv - rtv;
                  else pend_nxt.gw_data = {31'd0, $signed(rsv) < $signed(rtv)};
                  pend_nxt.cyc_inc  = 6'd1;
                  pend_nxt.acc_inc  = 2'd2;
                  pend_nxt.zero_inc = 2'(rs == 5'd0) + 2'(rt == 5'd0);
                  pend_nxt.dr       = 4'(dist_rs);
                  pend_nxt.dt       = 4'(dist_rt);
                  pend_nxt.push_en  = 1'b1;
                  pend_nxt.push_reg = rd;
                end
                default: pend_nxt.st = ST_BAD_INSTR;
              endcase
            end
            OP_J, OP_JAL: begin
              pend_nxt.gw_en    = (op == OP_JAL);
              pend_nxt.gw_addr  = REG_RA;
              pend_nxt.gw_data  = pc4;
              pend_nxt.npc      = {pc4[31:28], instr_r[25:0], 2'b00};
              pend_nxt.cyc_inc  = 6'd2;
              pend_nxt.push_en  = 1'b1;
              pend_nxt.push_reg = (op == OP_JAL) ? REG_RA : 5'd0;
            end
            OP_BEQ, OP_BNE: begin
              if ((op == OP_BEQ) == (rsv == rtv)) begin
                pend_nxt.npc     = pc4 + {simm[29:0], 2'b00};
                pend_nxt.cyc_inc = 6'd2;
              end else begin
                pend_nxt.cyc_inc = 6'd1;
              end
              pend_nxt.dr       = 4'(dist_rs);
              pend_nxt.dt       = 4'(dist_rt);
              pend_nxt.br_inc   = 1'b1;
              pend_nxt.acc_inc  = 2'd2;
              pend_nxt.zero_inc = 2'(rs == 5'd0) + 2'(rt == 5'd0);
              pend_nxt.push_en  = 1'b1;
            end
            OP_ADDIU, OP_ANDI: begin
              pend_nxt.gw_en    = 1'b1;
              pend_nxt.gw_addr  = rt;
              pend_nxt.gw_data  = (op == OP_ADDIU) ? (rsv + simm) : (rsv & uimm);
              pend_nxt.cyc_inc  = 6'd1;
              pend_nxt.acc_inc  = 2'd1;
              pend_nxt.zero_inc = {1'b0, rs == 5'd0};
              pend_nxt.dr       = 4'(dist_rs);
              pend_nxt.push_en  = 1'b1;
              pend_nxt.push_reg = rt;
            end
            OP_LUI: begin
              pend_nxt.gw_en    = 1'b1;
              pend_nxt.gw_addr  = rt;
              pend_nxt.gw_data  = {instr_r[15:0], 16'd0};
              pend_nxt.cyc_inc  = 6'd1;
              pend_nxt.push_en  = 1'b1;
              pend_nxt.push_reg = rt;
            end
            OP_TRAP: begin
              pend_nxt.cyc_inc = 6'd2;
              unique case (instr_r[3:0])
                TR_NEWLINE: begin
                  pend_nxt.pk       = PK_NEWLINE;
                  pend_nxt.push_en  = 1'b1;
                  pend_nxt.push_reg = rt;
                end
                TR_PRINT: begin
                  pend_nxt.pk       = PK_INT;
                  pend_nxt.pv       = rsv;
                  pend_nxt.zero_inc = {1'b0, rs == 5'd0};
                  pend_nxt.acc_inc  = 2'd1;
                  pend_nxt.dr       = 4'(dist_rs);
                  pend_nxt.push_en  = 1'b1;
                  pend_nxt.push_reg = rt;
                end
                TR_READ: begin
                  pend_nxt.pk       = PK_PROMPT;
                  pend_nxt.gw_en    = 1'b1;
                  pend_nxt.gw_addr  = rt;
                  pend_nxt.gw_data  = rdv_r;
                  pend_nxt.push_en  = 1'b1;
                  pend_nxt.push_reg = rt;
                end
                TR_HALT: begin
                  pend_nxt.st      = ST_HALT;
                  pend_nxt.push_en = 1'b1;
                end
                default: pend_nxt.st = ST_BAD_TRAP;
              endcase
            end
            OP_LW, OP_SW: begin
              // counts are filled in once the address checks out
              pend_nxt.dr       = 4'(dist_rs);
              pend_nxt.dt       = (op == OP_SW) ? 4'(dist_rt) : 4'd0;
              pend_nxt.gw_addr  = rt;
              pend_nxt.push_reg = (op == OP_LW) ? rt : 5'd0;
              state_nxt = S_MEM_CHK;
            end
            default: pend_nxt.st = ST_BAD_INSTR;
          endcase
        end
      end

      S_MEM_CHK: begin
        if (pend_r.ea[1:0] != 2'b00 || dm_off >= DM_BYTES) begin
          pend_nxt.st = (pend_r.ea[1:0] != 2'b00) ? ST_UNALIGNED : ST_RANGE;
          pend_nxt.dr = '0;
          pend_nxt.dt = '0;
          pend_nxt.push_reg = '0;
          state_nxt = S_FINISH;
        end else begin
          pend_nxt.cyc_inc  = 6'd6;
          pend_nxt.mem_inc  = 1'b1;
          pend_nxt.zero_inc = {1'b0, pend_r.gw_addr == 5'd0 && 1'b0} |
                              {1'b0, instr_r[25:21] == 5'd0};
          pend_nxt.acc_inc  = pend_r.is_lw ? 2'd1 : 2'd2;
          pend_nxt.push_en  = 1'b1;
          state_nxt = pend_r.is_lw ? S_MEM_RD : S_FINISH;
        end
      end

      S_MEM_RD: begin
        pend_nxt.gw_en   = 1'b1;
        pend_nxt.gw_data = dm_rdata;
        state_nxt = S_FINISH;
      end

      S_MULDIV: begin
        if (md_done) begin
          pend_nxt.hl_en = 1'b1;
          pend_nxt.hi    = md_hi;
          pend_nxt.lo    = md_lo;
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (fin_go) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      halted_r    <= 1'b0;
      pc_r        <= PC_INIT;
      hi_r        <= '0;
      lo_r        <= '0;
      cyc_r       <= '0;
      br_r        <= '0;
      mem_r       <= '0;
      zero_r      <= '0;
      acc_r       <= '0;
      ins_r       <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + AW'(1);
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cfg_we) pc_r <= cfg_wdata;
      if (fin_go) begin
        // commit every architectural effect of the item at once
        out_valid_r <= 1'b1;
        pc_r        <= pend_r.npc;
        if (pend_r.st != ST_OK) halted_r <= 1'b1;
        if (pend_r.hl_en) begin
          hi_r <= pend_r.hi;
          lo_r <= pend_r.lo;
        end
        cyc_r  <= cyc_new;
        br_r   <= br_new;
        mem_r  <= mem_new;
        zero_r <= zero_new;
        acc_r  <= acc_new;
        ins_r  <= ins_new;
        if (pend_r.push_en) begin
          for (int i = WINDOW_DEPTH - 1; i > 0; i--) win_r[i] <= win_r[i-1];
          win_r[0] <= pend_r.push_reg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (in_tvalid && in_tready) begin
      instr_r <= in_tdata[31:0];
      rdv_r   <= in_tdata[63:32];
    end
    if (fin_go) begin
      out_data_r <= {5'd0, ins_new, acc_new, zero_new, mem_new, br_new, cyc_new,
                     pend_r.dt, pend_r.dr, pend_r.pv, pend_r.st, pend_r.npc};
      out_user_r <= pend_r.pk;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- rtl/core/msx_checker.sv -----
module msx_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [271:0] out_tdata,
  input logic [1:0]   out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while busy");

  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd0 |-> out_tdata[34:32] == 3'd0)
    else $error("print request with bad status");

  a_print_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd2 |-> out_tdata[66:35] == 32'd0)
    else $error("print value without print request");

  a_fault_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] != 3'd0 |-> out_tdata[74:67] == 8'd0)
    else $error("distances reported on a stop");

endmodule

bind mips_subset_execute_with_stats msx_checker u_msx_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

// ----- test/exec_scoreboard.sv -----
`timescale 1ns / 1ps

import msx_pkg::*;

typedef struct {
  logic [31:0] npc;
  status_t     st;
  logic [1:0]  pk;
  logic [31:0] pv;
  logic [3:0]  dr;
  logic [3:0]  dt;
  logic [31:0] cyc;
  logic [31:0] br;
  logic [31:0] mem;
  logic [31:0] zero;
  logic [31:0] acc;
  logic [31:0] ins;
} exec_result_t;

class exec_scoreboard;
  logic [31:0] gpr [32];
  logic [31:0] hi_val, lo_val, pc;
  logic [31:0] dmem [1024];
  logic [4:0]  writers [8];
  logic [31:0] n_cyc, n_br, n_mem, n_zero, n_acc, n_ins;
  bit          halted;
  exec_result_t pending[$];
  int          errors;
  int          checked;

  function void reset_state();
    foreach (gpr[i]) gpr[i] = '0;
    gpr[28] = GP_INIT;
    gpr[29] = DATA_BASE + 32'd4096;
    hi_val = '0;
    lo_val = '0;
    pc = PC_INIT;
    foreach (dmem[i]) dmem[i] = '0;
    foreach (writers[i]) writers[i] = '0;
    {n_cyc, n_br, n_mem, n_zero, n_acc, n_ins} = '0;
    halted = 0;
  endfunction

  function void load_pc(logic [31:0] v);
    pc = v;
  endfunction

  function logic [3:0] distance(logic [4:0] r);
    if (r == 0) return '0;
    for (int i = 0; i < 8; i++)
      if (writers[i] == r) return 4'(i + 1);
    return '0;
  endfunction

  function void push_writer(logic [4:0] r);
    for (int i = 7; i > 0; i--) writers[i] = writers[i - 1];
    writers[0] = r;
  endfunction

  function void zero_read(logic [4:0] r);
    if (r == 0) n_zero++;
  endfunction

  function void note_item(logic [31:0] w, logic [31:0] rdv);
    exec_result_t r;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] uimm, simm, pc4, rsv, rtv, ea, off, ma, mb, q, rem;
    logic signed [63:0] a, b, prod;
    logic        na, nb;
    op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6];
    fn = w[5:0];
    uimm = {16'h0, w[15:0]};
    simm = {{16{w[15]}}, w[15:0]};
    r.st = ST_OK; r.pk = PK_NONE; r.pv = '0; r.dr = '0; r.dt = '0;
    if (halted) begin
      r.npc = pc;
      r.st = ST_HALT;
    end else begin
      n_ins++;
      pc4 = pc + 32'd4;
      r.npc = pc4;
      rsv = gpr[rs];
      rtv = gpr[rt];
      case (op)
        OP_SPECIAL: begin
          case (fn)
            FN_SLL, FN_SRA: begin
              gpr[rd] = (fn == FN_SLL) ? (rtv << sh) : 32'($signed(rtv) >>> sh);
              r.dt = distance(rt);
              push_writer(rd);
              n_cyc += 2; n_acc++;
              zero_read(rt);
            end
            FN_JR: begin
              r.npc = rsv;
              r.dr = distance(rs);
              push_writer(0);
              n_cyc += 2; n_acc++;
              zero_read(rs);
            end
            FN_MFHI, FN_MFLO: begin
              gpr[rd] = (fn == FN_MFHI) ? hi_val : lo_val;
              push_writer(rd);
              n_cyc += 2; n_acc++;
            end
            FN_MULT: begin
              a = $signed(rsv);
              b = $signed(rtv);
              prod = a * b;
              lo_val = prod[31:0];
              hi_val = prod[63:32];
              zero_read(rs); zero_read(rt);
              r.dr = distance(rs); r.dt = distance(rt);
              n_cyc += 32; n_acc += 2;
              push_writer(0);
            end
            FN_DIV: begin
              if (rtv == 0) begin
                r.st = ST_DIV_ZERO;
              end else begin
                na = rsv[31];
                nb = rtv[31];
                ma = na ? -rsv : rsv;
                mb = nb ? -rtv : rtv;
                q = ma / mb;
                rem = ma % mb;
                lo_val = (na != nb) ? -q : q;
                hi_val = na ? -rem : rem;
                r.dr = distance(rs); r.dt = distance(rt);
                n_cyc += 32; n_acc += 2;
                push_writer(0);
                zero_read(rs);
              end
            end
            FN_ADDU, FN_SUBU, FN_SLT: begin
              if (fn == FN_ADDU) gpr[rd] = rsv + rtv;
              else if (fn == FN_SUBU) gpr[rd] = rsv - rtv;
              else gpr[rd] = ($signed(rsv) < $signed(rtv)) ? 32'd1 : 32'd0;
              n_cyc += 1; n_acc += 2;
              zero_read(rs); zero_read(rt);
              r.dr = distance(rs); r.dt = distance(rt);
              push_writer(rd);
            end
            default: r.st = ST_BAD_INSTR;
          endcase
        end
        OP_J, OP_JAL: begin
          if (op == OP_JAL) gpr[REG_RA] = pc4;
          r.npc = {pc4[31:28], w[25:0], 2'b00};
          n_cyc += 2;
          push_writer(op == OP_JAL ? REG_RA : 5'd0);
        end
        OP_BEQ, OP_BNE: begin
          if ((op == OP_BEQ) == (rsv == rtv)) begin
            r.npc = pc4 + (simm << 2);
            n_cyc += 2;
          end else begin
            n_cyc += 1;
          end
          r.dr = distance(rs); r.dt = distance(rt);
          n_br++; n_acc += 2;
          zero_read(rs); zero_read(rt);
          push_writer(0);
        end
        OP_ADDIU, OP_ANDI: begin
          gpr[rt] = (op == OP_ADDIU) ? rsv + simm : (rsv & uimm);
          n_cyc += 1; n_acc++;
          zero_read(rs);
          r.dr = distance(rs);
          push_writer(rt);
        end
        OP_LUI: begin
          gpr[rt] = uimm << 16;
          n_cyc += 1;
          push_writer(rt);
        end
        OP_TRAP: begin
          n_cyc += 2;
          case (w[3:0])
            TR_NEWLINE: begin
              r.pk = PK_NEWLINE;
              push_writer(rt);
            end
            TR_PRINT: begin
              r.pk = PK_INT;
              r.pv = rsv;
              zero_read(rs);
              n_acc++;
              r.dr = distance(rs);
              push_writer(rt);
            end
            TR_READ: begin
              r.pk = PK_PROMPT;
              gpr[rt] = rdv;
              push_writer(rt);
            end
            TR_HALT: begin
              r.st = ST_HALT;
              push_writer(0);
            end
            default: r.st = ST_BAD_TRAP;
          endcase
        end
        OP_LW, OP_SW: begin
          ea = rsv + simm;
          off = ea - DATA_BASE;
          if (ea[1:0] != 0) r.st = ST_UNALIGNED;
          else if (off >= 32'd4096) r.st = ST_RANGE;
          else begin
            if (op == OP_LW) begin
              gpr[rt] = dmem[off[11:2]];
              n_acc++;
            end else begin
              dmem[off[11:2]] = rtv;
              n_acc += 2;
              r.dt = distance(rt);
            end
            n_cyc += 6; n_mem++;
            zero_read(rs);
            r.dr = distance(rs);
            push_writer(op == OP_LW ? rt : 5'd0);
          end
        end
        default: r.st = ST_BAD_INSTR;
      endcase
      gpr[0] = '0;
      pc = r.npc;
      if (r.st != ST_OK) halted = 1;
    end
    r.cyc = n_cyc; r.br = n_br; r.mem = n_mem;
    r.zero = n_zero; r.acc = n_acc; r.ins = n_ins;
    pending.push_back(r);
  endfunction

  function void compare(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %h, got %h", name, exp, act);
      errors++;
    end
  endfunction

  function void check_result(logic [271:0] d, logic [1:0] u);
    exec_result_t e;
    if (pending.size() == 0) begin
      $error("result with no expectation waiting: %h", d);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    compare("next_pc", e.npc, d[31:0]);
    compare("status", 32'(e.st), 32'(d[34:32]));
    compare("print_kind", 32'(e.pk), 32'(u));
    compare("print_value", e.pv, d[66:35]);
    compare("rs_distance", 32'(e.dr), 32'(d[70:67]));
    compare("rt_distance", 32'(e.dt), 32'(d[74:71]));
    compare("cycle_total", e.cyc, d[106:75]);
    compare("branch_total", e.br, d[138:107]);
    compare("memory_total", e.mem, d[170:139]);
    compare("zero_total", e.zero, d[202:171]);
    compare("access_total", e.acc, d[234:203]);
    compare("instr_total", e.ins, d[266:235]);
  endfunction
endclass

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import msx_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;     // instr_word[31:0], read_value[63:32]
  logic         out_tvalid;
  logic         out_tready;
  // next_pc, status, print_value, rs/rt distance, six counters, zero fill
  logic [271:0] out_tdata;
  logic [1:0]   out_tuser;    // print_kind[1:0]

  exec_scoreboard sb;
  bit hold_req;      // sender asks the receiver for one long hold-off
  int items_sent;
  int phases_run;

  mips_subset_execute_with_stats dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Hard limit on the whole run: far above the slowest legal run.
  initial begin
    #50ms;
    $display("FAIL mips_subset_execute_with_stats");
    $finish;
  end

  // Check every item the block hands over; ready is driven by us, so the
  // value seen at the edge is the pre-edge value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Receiver: own stall pattern that switches among three modes, plus one
  // long hold-off on request so the block backs up into its input.
  initial begin
    int mode;
    int left;
    out_tready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = 64;
        end
        left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Present one item and hold it until taken; valid stays high on return.
  task automatic send_item(logic [31:0] w, logic [31:0] rdv);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {rdv, w};
    do @(posedge clk); while (!in_tready);
    sb.note_item(w, rdv);
    items_sent++;
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Wait until every expected result has arrived, then let the block settle.
  task automatic drain();
    idle_gap(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_start_pc(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.load_pc(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  function automatic logic [4:0] pick_dest();
    logic [4:0] r;
    // keep sp intact so loads and stores have a valid base
    do r = 5'($urandom_range(0, 31)); while (r == 5'd29);
    return r;
  endfunction

  function automatic logic [15:0] mem_offset();
    return 16'(-4 * $urandom_range(1, 1024));
  endfunction

  // Build one well-formed instruction that cannot fault, given current state.
  function automatic logic [31:0] gen_instr();
    logic [4:0]  rs, rt, rd, sh;
    logic [15:0] imm;
    rs = 5'($urandom_range(0, 31));
    rt = 5'($urandom_range(0, 31));
    rd = pick_dest();
    sh = 5'($urandom_range(0, 31));
    imm = 16'($urandom);
    case ($urandom_range(0, 19))
      0:  return {OP_SPECIAL, rs, rt, rd, sh, FN_SLL};
      1:  return {OP_SPECIAL, rs, rt, rd, sh, FN_SRA};
      2:  return {OP_SPECIAL, rs, rt, rd, sh, FN_JR};
      3:  return {OP_SPECIAL, rs, rt, rd, sh, FN_MFHI};
      4:  return {OP_SPECIAL, rs, rt, rd, sh, FN_MFLO};
      5:  return {OP_SPECIAL, rs, rt, rd, sh, FN_MULT};
      6:  return {OP_SPECIAL, rs, rt, rd, sh, (sb.gpr[rt] != 0) ? FN_DIV : FN_MULT};
      7:  return {OP_SPECIAL, rs, rt, rd, sh, FN_ADDU};
      8:  return {OP_SPECIAL, rs, rt, rd, sh, FN_SUBU};
      9:  return {OP_SPECIAL, rs, rt, rd, sh, FN_SLT};
      10: return {OP_J, 26'($urandom)};
      11: return {OP_JAL, 26'($urandom)};
      12: return {OP_BEQ, rs, ($urandom_range(0, 1) ? rs : rt), imm};
      13: return {OP_BNE, rs, rt, imm};
      14: return {OP_ADDIU, rs, pick_dest(), imm};
      15: return {OP_ANDI, rs, pick_dest(), imm};
      16: return {OP_LUI, rs, pick_dest(), imm};
      17: begin
        case ($urandom_range(0, 2))
          0: return {OP_TRAP, rs, rt, imm[15:4], TR_NEWLINE};
          1: return {OP_TRAP, rs, rt, imm[15:4], TR_PRINT};
          default: return {OP_TRAP, rs, pick_dest(), imm[15:4], TR_READ};
        endcase
      end
      18: return {OP_LW, 5'd29, pick_dest(), mem_offset()};
      default: return {OP_SW, 5'd29, rt, mem_offset()};
    endcase
  endfunction

  // Bursts of random length with random gaps; gap zero keeps streaming.
  task automatic run_random(int n, bit long_hold);
    int burst;
    int gap;
    int done;
    done = 0;
    while (done < n) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && done < n; i++) begin
        if (long_hold && done == n / 2) hold_req = 1;
        send_item(gen_instr(), $urandom);
        done++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle_gap(gap);
    end
  endtask

  task automatic run_directed();
    // extremes: -1 and the most negative value
    send_item({OP_LUI, 5'd0, 5'd1, 16'hffff}, 32'h0);
    send_item({OP_ADDIU, 5'd1, 5'd1, 16'hffff}, 32'h0);
    send_item({OP_ADDIU, 5'd0, 5'd1, 16'hffff}, 32'h0);
    send_item({OP_LUI, 5'd0, 5'd2, 16'h8000}, 32'h0);
    // divide overflow, then read both halves
    send_item({OP_SPECIAL, 5'd2, 5'd1, 5'd0, 5'd0, FN_DIV}, 32'h0);
    send_item({OP_SPECIAL, 5'd0, 5'd0, 5'd3, 5'd0, FN_MFHI}, 32'h0);
    send_item({OP_SPECIAL, 5'd0, 5'd0, 5'd4, 5'd0, FN_MFLO}, 32'h0);
    send_item({OP_SPECIAL, 5'd2, 5'd2, 5'd0, 5'd0, FN_MULT}, 32'h0);
    send_item({OP_SPECIAL, 5'd0, 5'd0, 5'd5, 5'd0, FN_MFHI}, 32'h0);
    // shifts read rt; rs field is junk
    send_item({OP_SPECIAL, 5'd31, 5'd1, 5'd6, 5'd31, FN_SLL}, 32'h0);
    send_item({OP_SPECIAL, 5'd0, 5'd2, 5'd7, 5'd31, FN_SRA}, 32'h0);
    send_item({OP_SPECIAL, 5'd2, 5'd1, 5'd8, 5'd0, FN_ADDU}, 32'h0);
    send_item({OP_SPECIAL, 5'd2, 5'd1, 5'd9, 5'd0, FN_SUBU}, 32'h0);
    send_item({OP_SPECIAL, 5'd2, 5'd1, 5'd10, 5'd0, FN_SLT}, 32'h0);
    // write to register zero is dropped
    send_item({OP_ADDIU, 5'd1, 5'd0, 16'h1234}, 32'h0);
    send_item({OP_ANDI, 5'd1, 5'd11, 16'hffff}, 32'h0);
    send_item({OP_BEQ, 5'd0, 5'd0, 16'h8000}, 32'h0);
    send_item({OP_BNE, 5'd0, 5'd0, 16'h7fff}, 32'h0);
    send_item({OP_JAL, 26'h3ffffff}, 32'h0);
    send_item({OP_J, 26'h0}, 32'h0);
    // memory at both ends of the data range
    send_item({OP_SW, 5'd29, 5'd1, 16'hfffc}, 32'h0);
    send_item({OP_SW, 5'd29, 5'd2, 16'hf000}, 32'h0);
    send_item({OP_LW, 5'd29, 5'd12, 16'hf000}, 32'h0);
    // traps, read value at both extremes
    send_item({OP_TRAP, 5'd2, 5'd13, 12'h0, TR_PRINT}, 32'h0);
    send_item({OP_TRAP, 5'd0, 5'd14, 12'h0, TR_NEWLINE}, 32'h0);
    send_item({OP_TRAP, 5'd0, 5'd15, 12'h0, TR_READ}, 32'h8000_0000);
    send_item({OP_TRAP, 5'd0, 5'd16, 12'hfff, TR_READ}, 32'h7fff_ffff);
    // jump register to an unaligned target
    send_item({OP_ADDIU, 5'd0, 5'd17, 16'h0003}, 32'h0);
    send_item({OP_SPECIAL, 5'd17, 5'd0, 5'd0, 5'd0, FN_JR}, 32'h0);
  endtask

  // One fault halts the block for good, so it comes last; then a few
  // items that must all report the halted state.
  task automatic run_fault_and_halted();
    case ($urandom_range(0, 5))
      0: send_item({OP_TRAP, 5'd0, 5'd0, 12'h0, TR_HALT}, 32'h0);
      1: send_item({6'h3f, 26'h0}, 32'h0);
      2: send_item({OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd0, 6'h3f}, 32'h0);
      3: send_item({OP_TRAP, 5'd0, 5'd0, 12'h0, 4'h2}, 32'h0);
      4: send_item({OP_SPECIAL, 5'd1, 5'd0, 5'd0, 5'd0, FN_DIV}, 32'h0);
      default: send_item({($urandom_range(0, 1) ? OP_LW : OP_SW), 5'd28, 5'd1,
                          ($urandom_range(0, 1) ? 16'h0000 : 16'hfffd)}, 32'h0);
    endcase
    for (int i = 0; i < 6; i++) send_item($urandom, $urandom);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    hold_req = 0;
    items_sent = 0;
    phases_run = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Entry address written during the clearing pass.
    write_start_pc(PC_INIT);
    run_directed();
    drain();

    write_start_pc(32'h0000_0000);
    run_random(500, 1'b1);
    drain();

    write_start_pc(32'hffff_ffff);
    run_random(500, 1'b0);
    drain();

    write_start_pc(32'hffff_fffc);
    run_random(500, 1'b0);
    drain();

    write_start_pc($urandom);
    run_random(500, 1'b0);
    run_fault_and_halted();
    drain();

    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Run covered %0d items over %0d entry addresses, %0d results checked.",
             items_sent, phases_run, sb.checked);
    if (sb.errors == 0) begin
      $display("PASS mips_subset_execute_with_stats");
    end else begin
      $display("FAIL mips_subset_execute_with_stats");
    end
    $finish;
  end
endmodule
